>>> src/lorentz_boost_four_vector_macros.svh
// ----------------------------------------------------------------------------
// Lorentz boost assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LORENTZ_BOOST_FOUR_VECTOR_MACROS_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define LBST_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("lorentz boost assertion failed");
`define LBST_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lorentz boost assertion failed");
`else
`define LBST_ASSERT(lbl, ck, rn, prop)
`define LBST_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> src/lbst_pkg.sv
// ----------------------------------------------------------------------------
// Lorentz boost package
// Widths, payload types and the output saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package lbst_pkg;

  localparam int VW       = 32;             // vector component width
  localparam int BFB      = 30;             // beta fraction bits
  localparam int BW       = BFB + 2;        // beta width
  localparam int PROD_W   = VW + BW;        // one product b*s or b*b
  localparam int P_W      = PROD_W + 2;     // dot product b.s
  localparam int B2_W     = 2 * BW;         // beta squared
  localparam int D_W      = 2 * BFB + 1;    // 1 - beta^2, up to 2^(2F)
  localparam int RT_W     = BFB + 1;        // root r, up to 2^F
  localparam int OPR_W    = BFB + 2;        // 2^F + r
  localparam int DEN_W    = 2 * BFB + 2;    // (2^F + r) * r
  localparam int TM_W     = VW + OPR_W + 1; // t * (2^F + r)
  localparam int U_W      = P_W + 1;        // t*2^F + P and t*(2^F+r) + P
  localparam int MAG_W    = VW + BW + 1;    // magnitude of those sums
  localparam int LO_W     = (MAG_W + 1) / 2;
  localparam int HI_W     = MAG_W - LO_W;
  localparam int NUM_W    = MAG_W + BW;     // dividend magnitude
  localparam int SUM_W    = NUM_W + 2;      // s + signed quotient
  localparam int LANES    = 4;              // time lane and three space lanes

  localparam logic [B2_W-1:0]  ONE2 = B2_W'(1) << (2 * BFB);
  localparam logic [OPR_W-1:0] ONE  = OPR_W'(1) << BFB;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [BW-1:0] beta_t;

  typedef struct packed {
    vec_t                  t;
    vec_t                  sx;
    vec_t                  sy;
    vec_t                  sz;
    beta_t                 bx;
    beta_t                 by;
    beta_t                 bz;
    logic signed [P_W-1:0] p;
    logic [D_W-1:0]        d;
    logic                  err;
  } front_t;

  typedef struct packed {
    vec_t             t;
    vec_t             sx;
    vec_t             sy;
    vec_t             sz;
    logic             err;
    logic [LANES-1:0] neg;
  } side_t;

  typedef logic [LANES-1:0][NUM_W-1:0] num_arr_t;
  typedef logic [LANES-1:0][DEN_W-1:0] den_arr_t;

  function automatic vec_t sat_vec(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] smax;
    logic signed [SUM_W-1:0] smin;
    smax = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    smin = ~smax;
    if (v > smax) begin
      return smax[VW-1:0];
    end else if (v < smin) begin
      return smin[VW-1:0];
    end
    return v[VW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/lbst_front.sv
// ----------------------------------------------------------------------------
// Lorentz boost front end
// Two stages: products b*b and b*s, then beta squared, dot product and 1-beta^2.
// ----------------------------------------------------------------------------
`default_nettype none

module lbst_front import lbst_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   vld_in,
  input  wire vec_t   t_in,
  input  wire vec_t   sx_in,
  input  wire vec_t   sy_in,
  input  wire vec_t   sz_in,
  input  wire beta_t  bx_in,
  input  wire beta_t  by_in,
  input  wire beta_t  bz_in,
  output logic        vld_out,
  output front_t      pay_out
);

  logic                     vld1_r;
  vec_t                     t1_r, sx1_r, sy1_r, sz1_r;
  beta_t                    bx1_r, by1_r, bz1_r;
  logic signed [PROD_W-1:0] qx1_r, qy1_r, qz1_r;
  logic signed [PROD_W-1:0] px1_r, py1_r, pz1_r;
  logic signed [PROD_W-1:0] qx_nxt, qy_nxt, qz_nxt, px_nxt, py_nxt, pz_nxt;

  logic                     vld2_r;
  front_t                   pay2_r;
  front_t                   pay2_nxt;
  logic [B2_W-1:0]          beta2;

  always_comb begin
    qx_nxt = bx_in * bx_in;
    qy_nxt = by_in * by_in;
    qz_nxt = bz_in * bz_in;
    px_nxt = bx_in * sx_in;
    py_nxt = by_in * sy_in;
    pz_nxt = bz_in * sz_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r  <= t_in;
    sx1_r <= sx_in;
    sy1_r <= sy_in;
    sz1_r <= sz_in;
    bx1_r <= bx_in;
    by1_r <= by_in;
    bz1_r <= bz_in;
    qx1_r <= qx_nxt;
    qy1_r <= qy_nxt;
    qz1_r <= qz_nxt;
    px1_r <= px_nxt;
    py1_r <= py_nxt;
    pz1_r <= pz_nxt;
  end

  // Squares are never negative, so their bits are taken as unsigned.
  always_comb begin
    beta2        = $unsigned(qx1_r) + $unsigned(qy1_r) + $unsigned(qz1_r);
    pay2_nxt.t   = t1_r;
    pay2_nxt.sx  = sx1_r;
    pay2_nxt.sy  = sy1_r;
    pay2_nxt.sz  = sz1_r;
    pay2_nxt.bx  = bx1_r;
    pay2_nxt.by  = by1_r;
    pay2_nxt.bz  = bz1_r;
    pay2_nxt.p   = P_W'(px1_r) + P_W'(py1_r) + P_W'(pz1_r);
    pay2_nxt.err = (beta2 >= ONE2);
    pay2_nxt.d   = pay2_nxt.err ? '0 : (ONE2[D_W-1:0] - beta2[D_W-1:0]);
  end

  always_ff @(posedge clk) begin
    pay2_r <= pay2_nxt;
  end

  assign vld_out = vld2_r;
  assign pay_out = pay2_r;

endmodule

`default_nettype wire

>>> src/lbst_sqrt.sv
// ----------------------------------------------------------------------------
// Lorentz boost square root
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbst_sqrt import lbst_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   vld_in,
  input  wire front_t pay_in,
  output logic        vld_out,
  output front_t      pay_out,
  output logic [RT_W-1:0] root_out
);

  logic              vld_r  [RT_W];
  front_t            pay_r  [RT_W];
  logic [D_W-1:0]    rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int B = RT_W - 1 - k;
    logic            vld_prev;
    front_t          pay_prev;
    logic [D_W-1:0]  rem_prev;
    logic [RT_W-1:0] root_prev;
    logic [D_W:0]    trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign vld_prev  = vld_in;
      assign pay_prev  = pay_in;
      assign rem_prev  = pay_in.d;
      assign root_prev = '0;
    end else begin : g_next
      assign vld_prev  = vld_r[k-1];
      assign pay_prev  = pay_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B), with the low root bits still zero.
    always_comb begin
      trial = ((D_W+1)'(root_prev) << (B + 1)) + ((D_W+1)'(1) << (2 * B));
      fits  = ({1'b0, rem_prev} >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      pay_r[k]  <= pay_prev;
      rem_r[k]  <= fits ? (rem_prev - trial[D_W-1:0]) : rem_prev;
      root_r[k] <= fits ? (root_prev | (RT_W'(1) << B)) : root_prev;
    end
  end

  assign vld_out  = vld_r[RT_W-1];
  assign pay_out  = pay_r[RT_W-1];
  assign root_out = root_r[RT_W-1];

endmodule

`default_nettype wire

>>> src/lbst_scale.sv
// ----------------------------------------------------------------------------
// Lorentz boost scaling
// Five stages that form the dividends and divisors of the time and space lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module lbst_scale import lbst_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_in,
  input  wire front_t          pay_in,
  input  wire logic [RT_W-1:0] root_in,
  output logic                 vld_out,
  output num_arr_t             num_out,
  output den_arr_t             den_out,
  output side_t                side_out
);

  logic [4:0] vld_r;

  // Stage 1: the space divisor (2^F + r) * r, t*(2^F + r) and the time dividend t*2^F + P.
  front_t                   pay1_r;
  logic [RT_W-1:0]          root1_r;
  logic [DEN_W-1:0]         den1_r;
  logic signed [TM_W-1:0]   tm1_r;
  logic signed [U_W-1:0]    u1_r;
  logic [BW-1:0]            babs1_r [3];
  logic [OPR_W-1:0]         opr;

  // Stage 2 and 3: v = t*(2^F + r) + P and the magnitude of the time dividend, then the magnitude of v.
  front_t                   pay2_r, pay3_r, pay4_r;
  logic [RT_W-1:0]          root2_r, root3_r, root4_r;
  logic [DEN_W-1:0]         den2_r, den3_r, den4_r;
  logic [BW-1:0]            babs2_r [3];
  logic [BW-1:0]            babs3_r [3];
  logic signed [U_W-1:0]    v2_r;
  logic [MAG_W-1:0]         uabs2_r, uabs3_r, uabs4_r;
  logic                     uneg2_r, uneg3_r, uneg4_r;
  logic [MAG_W-1:0]         vabs3_r;
  logic                     vneg3_r, vneg4_r;
  logic signed [U_W-1:0]    uneg_val;
  logic signed [U_W-1:0]    vneg_val;

  // Stage 4: partial products of |v| * |b|.
  logic [LO_W+BW-1:0]       plo4_r [3];
  logic [HI_W+BW-1:0]       phi4_r [3];

  // Stage 5: lane outputs.
  num_arr_t                 num5_r;
  den_arr_t                 den5_r;
  side_t                    side5_r;

  beta_t                    b1 [3];
  beta_t                    b4 [3];

  always_comb begin
    opr   = ONE + OPR_W'(root_in);
    b1[0] = pay_in.bx;
    b1[1] = pay_in.by;
    b1[2] = pay_in.bz;
    b4[0] = pay4_r.bx;
    b4[1] = pay4_r.by;
    b4[2] = pay4_r.bz;
    uneg_val = -u1_r;
    vneg_val = -v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    pay1_r  <= pay_in;
    root1_r <= root_in;
    den1_r  <= DEN_W'(opr) * DEN_W'(root_in);
    tm1_r   <= pay_in.t * $signed({1'b0, opr});
    u1_r    <= (U_W'(pay_in.t) <<< BFB) + U_W'(pay_in.p);
    for (int i = 0; i < 3; i++) begin
      babs1_r[i] <= b1[i][BW-1] ? $unsigned(-b1[i]) : $unsigned(b1[i]);
    end

    pay2_r  <= pay1_r;
    root2_r <= root1_r;
    den2_r  <= den1_r;
    babs2_r <= babs1_r;
    v2_r    <= U_W'(tm1_r) + U_W'(pay1_r.p);
    uneg2_r <= u1_r[U_W-1];
    uabs2_r <= u1_r[U_W-1] ? uneg_val[MAG_W-1:0] : u1_r[MAG_W-1:0];

    pay3_r  <= pay2_r;
    root3_r <= root2_r;
    den3_r  <= den2_r;
    babs3_r <= babs2_r;
    uneg3_r <= uneg2_r;
    uabs3_r <= uabs2_r;
    vneg3_r <= v2_r[U_W-1];
    vabs3_r <= v2_r[U_W-1] ? vneg_val[MAG_W-1:0] : v2_r[MAG_W-1:0];

    pay4_r  <= pay3_r;
    root4_r <= root3_r;
    den4_r  <= den3_r;
    uneg4_r <= uneg3_r;
    uabs4_r <= uabs3_r;
    vneg4_r <= vneg3_r;
    for (int i = 0; i < 3; i++) begin
      plo4_r[i] <= vabs3_r[LO_W-1:0] * babs3_r[i];
      phi4_r[i] <= vabs3_r[MAG_W-1:LO_W] * babs3_r[i];
    end

    num5_r[0]   <= NUM_W'(uabs4_r);
    den5_r[0]   <= DEN_W'(root4_r);
    side5_r.t   <= pay4_r.t;
    side5_r.sx  <= pay4_r.sx;
    side5_r.sy  <= pay4_r.sy;
    side5_r.sz  <= pay4_r.sz;
    side5_r.err <= pay4_r.err;
    side5_r.neg[0] <= uneg4_r;
    for (int i = 0; i < 3; i++) begin
      num5_r[i+1] <= (NUM_W'(phi4_r[i]) << LO_W) + NUM_W'(plo4_r[i]);
      den5_r[i+1] <= den4_r;
      side5_r.neg[i+1] <= vneg4_r ^ b4[i][BW-1];
    end
  end

  assign vld_out  = vld_r[4];
  assign num_out  = num5_r;
  assign den_out  = den5_r;
  assign side_out = side5_r;

endmodule

`default_nettype wire

>>> src/lbst_div.sv
// ----------------------------------------------------------------------------
// Lorentz boost divider
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbst_div import lbst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     vld_in,
  input  wire num_arr_t num_in,
  input  wire den_arr_t den_in,
  input  wire side_t    side_in,
  output logic          vld_out,
  output num_arr_t      quo_out,
  output side_t         side_out
);

  logic     vld_r  [NUM_W];
  side_t    side_r [NUM_W];
  num_arr_t num_r  [NUM_W];
  den_arr_t den_r  [NUM_W];
  den_arr_t rem_r  [NUM_W];

  // The dividend shifts out at the top while quotient bits shift in below.
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic     vld_prev;
    side_t    side_prev;
    num_arr_t num_prev;
    den_arr_t den_prev;
    den_arr_t rem_prev;
    num_arr_t num_nxt;
    den_arr_t rem_nxt;
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;

    if (k == 0) begin : g_first
      assign vld_prev  = vld_in;
      assign side_prev = side_in;
      assign num_prev  = num_in;
      assign den_prev  = den_in;
      assign rem_prev  = '0;
    end else begin : g_next
      assign vld_prev  = vld_r[k-1];
      assign side_prev = side_r[k-1];
      assign num_prev  = num_r[k-1];
      assign den_prev  = den_r[k-1];
      assign rem_prev  = rem_r[k-1];
    end

    always_comb begin
      shifted = '0;
      diff    = '0;
      for (int l = 0; l < LANES; l++) begin
        shifted    = {rem_prev[l], num_prev[l][NUM_W-1]};
        diff       = shifted - {1'b0, den_prev[l]};
        num_nxt[l] = {num_prev[l][NUM_W-2:0], ~diff[DEN_W]};
        rem_nxt[l] = diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_prev;
      num_r[k]  <= num_nxt;
      den_r[k]  <= den_prev;
      rem_r[k]  <= rem_nxt;
    end
  end

  assign vld_out  = vld_r[NUM_W-1];
  assign quo_out  = num_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

`default_nettype wire

>>> src/lorentz_boost_four_vector.sv
// ----------------------------------------------------------------------------
// Lorentz boost of a four-vector
// Fully pipelined boost: one word in and one word out per clock.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy is always low.
// The boosted word appears on the out_ ports with out_valid high for one cycle,
// and the receiver cannot hold it off. The latency is set by the 31-stage
// square root and the 97-stage divider, one bit per stage, plus two front stages,
// five scaling stages and one output stage. A velocity with beta squared of one
// or more returns the vector unchanged with out_superluminal_error set; all other
// results are truncated toward zero and saturated to the 32-bit range.
`default_nettype none
`include "lorentz_boost_four_vector_macros.svh"

module lorentz_boost_four_vector import lbst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire vec_t  in_time_in,
  input  wire vec_t  in_space_x_in,
  input  wire vec_t  in_space_y_in,
  input  wire vec_t  in_space_z_in,
  input  wire beta_t in_beta_x,
  input  wire beta_t in_beta_y,
  input  wire beta_t in_beta_z,
  output logic       out_valid,
  output vec_t       out_time_out,
  output vec_t       out_space_x_out,
  output vec_t       out_space_y_out,
  output vec_t       out_space_z_out,
  output logic       out_superluminal_error
);

  logic            fr_vld;
  front_t          fr_pay;
  logic            sq_vld;
  front_t          sq_pay;
  logic [RT_W-1:0] sq_root;
  logic            sc_vld;
  num_arr_t        sc_num;
  den_arr_t        sc_den;
  side_t           sc_side;
  logic            div_vld;
  num_arr_t        div_quo;
  side_t           div_side;

  logic                    out_valid_r;
  vec_t                    time_r, sx_r, sy_r, sz_r;
  logic                    err_r;
  vec_t                    time_nxt, sx_nxt, sy_nxt, sz_nxt;
  logic signed [SUM_W-1:0] qs [LANES];

  assign busy = 1'b0;

  lbst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (start),
    .t_in    (in_time_in),
    .sx_in   (in_space_x_in),
    .sy_in   (in_space_y_in),
    .sz_in   (in_space_z_in),
    .bx_in   (in_beta_x),
    .by_in   (in_beta_y),
    .bz_in   (in_beta_z),
    .vld_out (fr_vld),
    .pay_out (fr_pay)
  );

  lbst_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (fr_vld),
    .pay_in   (fr_pay),
    .vld_out  (sq_vld),
    .pay_out  (sq_pay),
    .root_out (sq_root)
  );

  lbst_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (sq_vld),
    .pay_in   (sq_pay),
    .root_in  (sq_root),
    .vld_out  (sc_vld),
    .num_out  (sc_num),
    .den_out  (sc_den),
    .side_out (sc_side)
  );

  lbst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (sc_vld),
    .num_in   (sc_num),
    .den_in   (sc_den),
    .side_in  (sc_side),
    .vld_out  (div_vld),
    .quo_out  (div_quo),
    .side_out (div_side)
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qs[l] = div_side.neg[l] ? -SUM_W'(div_quo[l]) : SUM_W'(div_quo[l]);
    end
    if (div_side.err) begin
      time_nxt = div_side.t;
      sx_nxt   = div_side.sx;
      sy_nxt   = div_side.sy;
      sz_nxt   = div_side.sz;
    end else begin
      time_nxt = sat_vec(qs[0]);
      sx_nxt   = sat_vec(SUM_W'(div_side.sx) + qs[1]);
      sy_nxt   = sat_vec(SUM_W'(div_side.sy) + qs[2]);
      sz_nxt   = sat_vec(SUM_W'(div_side.sz) + qs[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sz_r   <= sz_nxt;
    err_r  <= div_side.err;
  end

  assign out_valid              = out_valid_r;
  assign out_time_out           = time_r;
  assign out_space_x_out        = sx_r;
  assign out_space_y_out        = sy_r;
  assign out_space_z_out        = sz_r;
  assign out_superluminal_error = err_r;

  // A subluminal velocity always leaves a root between one and 2^F.
  `LBST_ASSERT(a_root_range, clk, rst_n, !sq_vld || sq_pay.err || (sq_root != '0 && sq_root <= RT_W'(ONE)))
  // A superluminal word must leave the pipeline untouched.
  `LBST_ASSERT_NEXT(a_err_pass, clk, rst_n, div_vld && div_side.err, out_superluminal_error && out_time_out == $past(div_side.t) && out_space_x_out == $past(div_side.sx))
  `LBST_ASSERT_NEXT(a_valid_follow, clk, rst_n, !div_vld, !out_valid)

endmodule

`default_nettype wire

>>> tb/sv/lorentz_boost_four_vector_tb.sv
// ----------------------------------------------------------------------------
// Lorentz boost four-vector testbench
// Streams directed and random vectors and velocities into the pipelined boost,
// predicts every boosted word with exact wide integer arithmetic and compares
// each output word field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lorentz_boost_four_vector_tb;
  import lbst_pkg::*;

  localparam int LATENCY   = 136;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 600;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    vec_t  t;
    vec_t  sx;
    vec_t  sy;
    vec_t  sz;
    beta_t bx;
    beta_t by;
    beta_t bz;
  } four_vec_t;

  typedef struct {
    vec_t t;
    vec_t sx;
    vec_t sy;
    vec_t sz;
    logic err;
  } boosted_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  vec_t  in_time_in, in_space_x_in, in_space_y_in, in_space_z_in;
  beta_t in_beta_x, in_beta_y, in_beta_z;
  logic  out_valid;
  vec_t  out_time_out, out_space_x_out, out_space_y_out, out_space_z_out;
  logic  out_superluminal_error;

  four_vec_t pending_vectors[$];
  boosted_t  expected_boosts[$];
  int        n_mismatch = 0;
  int        n_accepted = 0;
  int        n_checked  = 0;
  int        n_superluminal = 0;
  int        gap_left = 0;
  logic      taken = 1'b0;
  int        idle_cycles = 0;

  lorentz_boost_four_vector dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_time_in(in_time_in), .in_space_x_in(in_space_x_in),
    .in_space_y_in(in_space_y_in), .in_space_z_in(in_space_z_in),
    .in_beta_x(in_beta_x), .in_beta_y(in_beta_y), .in_beta_z(in_beta_z),
    .out_valid(out_valid), .out_time_out(out_time_out),
    .out_space_x_out(out_space_x_out), .out_space_y_out(out_space_y_out),
    .out_space_z_out(out_space_z_out),
    .out_superluminal_error(out_superluminal_error)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic vec_t clamp_vec(input wide_t v);
    if (v > wide_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -wide_t'(64'sh80000000)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Exact boost: all intermediates are wide enough that only the outputs saturate.
  function automatic boosted_t boost_vector(input four_vec_t a);
    boosted_t res;
    wide_t t, s[3], b[3], beta2, dot, one, diff, root, cand, opr, den, u, v, q;
    t = a.t;
    s[0] = a.sx; s[1] = a.sy; s[2] = a.sz;
    b[0] = a.bx; b[1] = a.by; b[2] = a.bz;
    one = wide_t'(1) <<< BFB;
    beta2 = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      beta2 += b[i] * b[i];
      dot += b[i] * s[i];
    end
    if (beta2 >= one * one) begin
      res.t = a.t; res.sx = a.sx; res.sy = a.sy; res.sz = a.sz;
      res.err = 1'b1;
      return res;
    end
    diff = one * one - beta2;
    root = 0;
    for (int k = BFB; k >= 0; k--) begin
      cand = root | (wide_t'(1) <<< k);
      if (cand * cand <= diff) root = cand;
    end
    u = t * one + dot;
    res.t = clamp_vec(u / root);
    opr = one + root;
    den = opr * root;
    v = t * opr + dot;
    q = (v * b[0]) / den; res.sx = clamp_vec(s[0] + q);
    q = (v * b[1]) / den; res.sy = clamp_vec(s[1] + q);
    q = (v * b[2]) / den; res.sz = clamp_vec(s[2] + q);
    res.err = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input vec_t got, input vec_t want);
    $display("mismatch on word %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_mismatch++;
  endtask

  // Driver: a word stays on the inputs until the edge that takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_vectors.size() > 0) begin
        four_vec_t nx;
        nx = pending_vectors.pop_front();
        in_time_in <= nx.t; in_space_x_in <= nx.sx;
        in_space_y_in <= nx.sy; in_space_z_in <= nx.sz;
        in_beta_x <= nx.bx; in_beta_y <= nx.by; in_beta_z <= nx.bz;
        start <= 1'b1;
        // Long runs back to back, then runs with random gaps.
        gap_left <= ((n_accepted / 64) % 2 == 0) ? 0 : $urandom_range(0, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: records accepted words and checks output words.
  always @(posedge clk) begin
    boosted_t want;
    four_vec_t a;
    logic took;
    took = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        a.t = in_time_in; a.sx = in_space_x_in; a.sy = in_space_y_in;
        a.sz = in_space_z_in; a.bx = in_beta_x; a.by = in_beta_y; a.bz = in_beta_z;
        want = boost_vector(a);
        if (want.err) n_superluminal++;
        expected_boosts.push_back(want);
        n_accepted++;
        took = 1'b1;
      end
      if (out_valid) begin
        if (expected_boosts.size() == 0) begin
          $display("unexpected output word");
          n_mismatch++;
        end else begin
          want = expected_boosts.pop_front();
          if (out_time_out !== want.t) report_mismatch("time", out_time_out, want.t);
          if (out_space_x_out !== want.sx) report_mismatch("x", out_space_x_out, want.sx);
          if (out_space_y_out !== want.sy) report_mismatch("y", out_space_y_out, want.sy);
          if (out_space_z_out !== want.sz) report_mismatch("z", out_space_z_out, want.sz);
          if (out_superluminal_error !== want.err)
            report_mismatch("superluminal flag", vec_t'(out_superluminal_error),
                            vec_t'(want.err));
          n_checked++;
        end
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("timeout with %0d words outstanding", expected_boosts.size());
        $display("lorentz_boost_four_vector regression: fail");
        $finish;
      end
      idle_cycles <= (took || out_valid) ? 0 : idle_cycles + 1;
    end
    taken <= took;
  end

  function automatic beta_t rand_beta_axis(input int kind);
    case (kind)
      0: return 0;
      1: return beta_t'($signed($urandom) >>> $urandom_range(2, 24));
      default: return beta_t'($urandom);
    endcase
  endfunction

  function automatic vec_t rand_component();
    if ($urandom_range(0, 2) == 0) return vec_t'($signed($urandom) >>> $urandom_range(0, 28));
    return vec_t'($urandom);
  endfunction

  task automatic add_vector(input vec_t t, input vec_t x, input vec_t y, input vec_t z,
                            input beta_t bx, input beta_t by, input beta_t bz);
    four_vec_t a;
    a.t = t; a.sx = x; a.sy = y; a.sz = z; a.bx = bx; a.by = by; a.bz = bz;
    pending_vectors.push_back(a);
  endtask

  initial begin
    four_vec_t a;
    int kind, axis;
    beta_t nb;
    rst_n = 1'b0;
    start = 1'b0;
    in_time_in = 0; in_space_x_in = 0; in_space_y_in = 0; in_space_z_in = 0;
    in_beta_x = 0; in_beta_y = 0; in_beta_z = 0;

    // Directed: rest frame, extremes, speed of light and just below it.
    add_vector(32'sd65536, 32'sd131072, -32'sd65536, 32'sd7, 0, 0, 0);
    add_vector(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
    add_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh20000000, 32'sh10000000, -32'sh10000000);
    add_vector(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               -32'sh20000000, 32'sh08000000, 32'sh08000000);
    add_vector(32'sd65536, 32'sd65536, 0, 0, 32'sh40000000, 0, 0);
    add_vector(32'sd65536, 0, 32'sd65536, 0, 0, -32'sh40000000, 0);
    add_vector(32'sd100, 32'sd200, 32'sd300, 32'sd400, 32'sh80000000, 0, 0);
    add_vector(32'sd100, 32'sd200, 32'sd300, 32'sd400,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_vector(32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sh3fffffff, 0, 0);
    add_vector(-32'sd65536, 32'sd12345, 32'sd0, 32'sd1, 0, 0, -32'sh3fffffff);
    add_vector(32'sh7fffffff, 32'sh7fffffff, 0, 0, 32'sh3ffffff0, 0, 0);
    add_vector(32'sh80000000, 32'sh7fffffff, 0, 0, 32'sh3ffffff0, 0, 0);
    add_vector(32'sd65536, 32'sd0, 32'sd0, 32'sd0,
               32'sh24f34e8b, 32'sh24f34e8b, 32'sh24f34e8b);
    add_vector(-32'sd1, 32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 32'sd1);
    add_vector(0, 0, 0, 0, 32'sh20000000, 32'sh20000000, 32'sh20000000);

    for (int n = 0; n < N_RANDOM; n++) begin
      a.t = rand_component(); a.sx = rand_component();
      a.sy = rand_component(); a.sz = rand_component();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        a.bx = rand_beta_axis(1); a.by = rand_beta_axis(1); a.bz = rand_beta_axis(1);
      end else if (kind < 7) begin
        // Near light speed along one axis: very large gamma.
        axis = $urandom_range(0, 2);
        nb = beta_t'(32'sh40000000 - $urandom_range(1, 4000));
        if ($urandom_range(0, 1)) nb = -nb;
        a.bx = (axis == 0) ? nb : 0;
        a.by = (axis == 1) ? nb : 0;
        a.bz = (axis == 2) ? nb : 0;
      end else if (kind == 7) begin
        a.bx = 0; a.by = 0; a.bz = 0;
      end else begin
        a.bx = rand_beta_axis(2); a.by = rand_beta_axis(2); a.bz = rand_beta_axis(2);
      end
      pending_vectors.push_back(a);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_vectors.size() == 0 && !start);
    wait (expected_boosts.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("boosted %0d words, %0d of them superluminal, %0d checked",
             n_accepted, n_superluminal, n_checked);
    if (n_mismatch == 0 && expected_boosts.size() == 0) begin
      $display("lorentz_boost_four_vector regression: pass");
    end else begin
      $display("lorentz_boost_four_vector regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
